>>> sv/gvtm_pkg.sv
// ----------------------------------------------------------------------------
// gvtm_pkg
// Shared types and constants of the grid voltage trip monitor.
// ----------------------------------------------------------------------------
package gvtm_pkg;

	localparam int PHASES  = 3;
	localparam int VOLT_W  = 16;
	localparam int CNT_W   = 16;
	localparam int PHASE_W = 2;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_UNDER_THR = 3'd0,
		REG_OVER_THR  = 3'd1,
		REG_RECOVER_W = 3'd2,
		REG_UNDER_TIM = 3'd3,
		REG_OVER_TIM  = 3'd4,
		REG_RECOVER_T = 3'd5,
		REG_PHASE_CNT = 3'd6
	} cfg_reg_t;

	// levels and limits seen by every lane
	typedef struct packed {
		logic [VOLT_W-1:0] deep_lvl;
		logic [VOLT_W-1:0] under_lvl;
		logic [VOLT_W-1:0] over_lvl;
		logic [VOLT_W-1:0] far_lvl;
		logic [VOLT_W-1:0] back_lo;
		logic [VOLT_W-1:0] back_hi;
		logic [CNT_W-1:0]  t_under;
		logic [CNT_W-1:0]  t_deep;
		logic [CNT_W-1:0]  t_over;
		logic [CNT_W-1:0]  t_far;
	} lane_cfg_t;

	typedef struct packed {
		logic trip;
		logic out_win;
	} lane_stat_t;

	typedef struct packed {
		logic upd;
		logic clr;
	} lane_ctrl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

>>> sv/grid_voltage_trip_monitor.sv
// ----------------------------------------------------------------------------
// grid_voltage_trip_monitor
// Two-stage over/under voltage relay over up to three phases.
// ----------------------------------------------------------------------------
// result: registered in the output register, or in the skid entry while held
// throughput: one sample per cycle while the skid entry is empty, set by the
//   counter update loop in the phase lanes and the reconnect counter
// output stall: the skid entry takes one more beat, then s_tready drops
// reset: all counters clear, valid flags and config registers go to zero, phase count to three
// ----------------------------------------------------------------------------
module grid_voltage_trip_monitor
	import gvtm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [47:0]      s_tdata,   // volt_phase_a, volt_phase_b, volt_phase_c
	input  logic             s_tuser,   // fault_latched
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata    // fault, zero padding
);

	logic [CFG_W-1:0]   under_thr_q, over_thr_q, recover_w_q, under_tim_q, over_tim_q;
	logic [CNT_W-1:0]   recover_t_q;
	logic [PHASE_W-1:0] phase_cnt_q;
	logic [PHASE_W-1:0] n_act;
	lane_cfg_t          lcfg;
	lane_stat_t         stat [PHASES];
	lane_ctrl_t         ctrl [PHASES];
	logic               accept;
	logic               fault;
	logic               out_valid_q, out_q, skid_valid_q, skid_q;
	logic               m_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			under_thr_q <= '0;
			over_thr_q  <= '0;
			recover_w_q <= '0;
			under_tim_q <= '0;
			over_tim_q  <= '0;
			recover_t_q <= '0;
			phase_cnt_q <= PHASE_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNDER_THR: under_thr_q <= cfg_data;
				REG_OVER_THR:  over_thr_q  <= cfg_data;
				REG_RECOVER_W: recover_w_q <= cfg_data;
				REG_UNDER_TIM: under_tim_q <= cfg_data;
				REG_OVER_TIM:  over_tim_q  <= cfg_data;
				REG_RECOVER_T: recover_t_q <= cfg_data[CNT_W-1:0];
				REG_PHASE_CNT: phase_cnt_q <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_act = (phase_cnt_q > PHASE_W'(PHASES)) ? PHASE_W'(PHASES) : phase_cnt_q;

	assign lcfg.deep_lvl  = under_thr_q[15:0];
	assign lcfg.under_lvl = under_thr_q[31:16];
	assign lcfg.over_lvl  = over_thr_q[15:0];
	assign lcfg.far_lvl   = over_thr_q[31:16];
	assign lcfg.back_lo   = recover_w_q[15:0];
	assign lcfg.back_hi   = recover_w_q[31:16];
	assign lcfg.t_under   = under_tim_q[15:0];
	assign lcfg.t_deep    = under_tim_q[31:16];
	assign lcfg.t_over    = over_tim_q[15:0];
	assign lcfg.t_far     = over_tim_q[31:16];

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	for (genvar g = 0; g < PHASES; g++) begin : g_lane
		gvtm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.volt   (s_tdata[g*VOLT_W +: VOLT_W]),
			.cfg    (lcfg),
			.ctrl   (ctrl[g]),
			.stat   (stat[g])
		);
	end

	gvtm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.n_act        (n_act),
		.fault_mode   (s_tuser),
		.accept       (accept),
		.recover_time (recover_t_q),
		.ctrl         (ctrl),
		.fault        (fault)
	);

	// output register with one skid entry
	assign m_take = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !m_take) begin
			if (accept)
				skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !m_take) begin
			if (accept)
				skid_q <= fault;
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (accept) begin
			out_q <= fault;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted beat produced no result");

endmodule

>>> sv/gvtm_lane.sv
// ----------------------------------------------------------------------------
// gvtm_lane
// One phase: voltage class, duration counters and trip candidate.
// ----------------------------------------------------------------------------
module gvtm_lane
	import gvtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VOLT_W-1:0] volt,
	input  lane_cfg_t         cfg,
	input  lane_ctrl_t        ctrl,
	output lane_stat_t        stat
);

	logic [CNT_W-1:0] deep_q, under_q, over_q, far_q;
	logic [CNT_W-1:0] deep_d, under_d, over_d, far_d;
	logic             trip;

	always_comb begin
		deep_d  = '0;
		under_d = '0;
		over_d  = '0;
		far_d   = '0;
		trip    = 1'b0;
		if (volt < cfg.deep_lvl) begin
			deep_d  = sat_inc(deep_q);
			under_d = sat_inc(under_q);
			if (deep_d >= cfg.t_deep) begin
				deep_d  = '0;
				under_d = '0;
				trip    = 1'b1;
			end
		end else if (volt < cfg.under_lvl) begin
			under_d = sat_inc(under_q);
			if (under_d >= cfg.t_under) begin
				under_d = '0;
				trip    = 1'b1;
			end
		end else if (volt > cfg.far_lvl) begin
			over_d = sat_inc(over_q);
			far_d  = sat_inc(far_q);
			if (far_d >= cfg.t_far) begin
				over_d = '0;
				far_d  = '0;
				trip   = 1'b1;
			end
		end else if (volt > cfg.over_lvl) begin
			over_d = sat_inc(over_q);
			if (over_d >= cfg.t_over) begin
				over_d = '0;
				trip   = 1'b1;
			end
		end
	end

	assign stat.trip    = trip;
	assign stat.out_win = (volt < cfg.back_lo) || (volt > cfg.back_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deep_q  <= '0;
			under_q <= '0;
			over_q  <= '0;
			far_q   <= '0;
		end else if (ctrl.clr) begin
			deep_q  <= '0;
			under_q <= '0;
			over_q  <= '0;
			far_q   <= '0;
		end else if (ctrl.upd) begin
			deep_q  <= deep_d;
			under_q <= under_d;
			over_q  <= over_d;
			far_q   <= far_d;
		end
	end

endmodule

>>> sv/gvtm_merge.sv
// ----------------------------------------------------------------------------
// gvtm_merge
// Combines lane findings: first-trip priority, reconnect counter, result.
// ----------------------------------------------------------------------------
module gvtm_merge
	import gvtm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_stat_t         stat [PHASES],
	input  logic [PHASE_W-1:0] n_act,
	input  logic               fault_mode,
	input  logic               accept,
	input  logic [CNT_W-1:0]   recover_time,
	output lane_ctrl_t         ctrl [PHASES],
	output logic               fault
);

	logic [CNT_W-1:0]  rc_q;
	logic [CNT_W-1:0]  rc_next;
	logic              blocked;
	logic              restart;
	logic              release_now;
	logic              clr_all;
	logic [PHASES-1:0] upd_trip;

	always_comb begin
		blocked = 1'b0;
		restart = 1'b0;
		for (int i = 0; i < PHASES; i++) begin
			ctrl[i].upd = accept && !fault_mode && (PHASE_W'(i) < n_act) && !blocked;
			ctrl[i].clr = clr_all;
			upd_trip[i] = ctrl[i].upd && stat[i].trip;
			// a trip stops the scan of later phases
			if ((PHASE_W'(i) < n_act) && stat[i].trip)
				blocked = 1'b1;
			if ((PHASE_W'(i) < n_act) && stat[i].out_win)
				restart = 1'b1;
		end
	end

	assign rc_next     = restart ? CNT_W'(1) : sat_inc(rc_q);
	assign release_now = rc_next > recover_time;
	assign clr_all     = accept && fault_mode && release_now;
	assign fault       = fault_mode ? !release_now : blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
		end else if (accept && fault_mode) begin
			rc_q <= release_now ? '0 : rc_next;
		end
	end

	a_one_trip: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(upd_trip))
		else $error("more than one lane tripped on one beat");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_all |=> (rc_q == '0))
		else $error("reconnect counter not cleared on release");

	a_modes_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl[0].clr |-> !ctrl[0].upd && fault_mode && !fault)
		else $error("release overlaps a normal-mode update");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid voltage trip monitor.
// Drives phase voltage samples with random gaps, predicts each trip or
// release decision and compares it with every result beat.
// ----------------------------------------------------------------------------
module tb;
	import gvtm_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;   // outside the register map
	localparam int               TIMEOUT_NS = 16_000_000;

	typedef bit [PHASES-1:0][VOLT_W-1:0] volt_set_t;
	typedef enum {V_DEEP, V_UNDER, V_NORMAL, V_OVER, V_FAR, V_WINDOW, V_ANY} volt_kind_t;

	class trip_scoreboard;
		bit [CFG_W-1:0]   under_thr, over_thr, recover_win, under_tim, over_tim;
		bit [CNT_W-1:0]   recover_tim;
		bit [PHASE_W-1:0] phase_cnt;
		bit [CNT_W-1:0]   under_cnt [PHASES];
		bit [CNT_W-1:0]   deep_cnt [PHASES];
		bit [CNT_W-1:0]   over_cnt [PHASES];
		bit [CNT_W-1:0]   far_cnt [PHASES];
		bit [CNT_W-1:0]   reconnect_cnt;
		bit               fault_due [$];
		int               errors;

		function new();
			under_thr   = '0;
			over_thr    = '0;
			recover_win = '0;
			under_tim   = '0;
			over_tim    = '0;
			recover_tim = '0;
			phase_cnt   = 2'd3;
			errors      = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			for (int p = 0; p < PHASES; p++) begin
				under_cnt[p] = '0;
				deep_cnt[p]  = '0;
				over_cnt[p]  = '0;
				far_cnt[p]   = '0;
			end
			reconnect_cnt = '0;
		endfunction

		// counters stick at all ones
		function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_UNDER_THR: under_thr = val;
				REG_OVER_THR:  over_thr = val;
				REG_RECOVER_W: recover_win = val;
				REG_UNDER_TIM: under_tim = val;
				REG_OVER_TIM:  over_tim = val;
				REG_RECOVER_T: recover_tim = val[CNT_W-1:0];
				REG_PHASE_CNT: phase_cnt = val[PHASE_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_sample(volt_set_t volt, bit in_fault);
			int               n;
			bit               trip;
			bit [VOLT_W-1:0]  x;
			bit [VOLT_W-1:0]  deep_lvl, under_lvl, over_lvl, far_lvl, win_lo, win_hi;
			bit [CNT_W-1:0]   t_under, t_deep, t_over, t_far;
			deep_lvl  = under_thr[15:0];
			under_lvl = under_thr[31:16];
			over_lvl  = over_thr[15:0];
			far_lvl   = over_thr[31:16];
			win_lo    = recover_win[15:0];
			win_hi    = recover_win[31:16];
			t_under   = under_tim[15:0];
			t_deep    = under_tim[31:16];
			t_over    = over_tim[15:0];
			t_far     = over_tim[31:16];
			n    = (phase_cnt > PHASES) ? PHASES : int'(phase_cnt);
			trip = 1'b0;
			if (!in_fault) begin
				// first tripping phase ends the scan
				for (int p = 0; p < n && !trip; p++) begin
					x = volt[p];
					if (x < deep_lvl) begin
						deep_cnt[p]  = bump(deep_cnt[p]);
						under_cnt[p] = bump(under_cnt[p]);
						over_cnt[p]  = '0;
						far_cnt[p]   = '0;
						if (deep_cnt[p] >= t_deep) begin
							deep_cnt[p]  = '0;
							under_cnt[p] = '0;
							trip = 1'b1;
						end
					end else if (x < under_lvl) begin
						deep_cnt[p]  = '0;
						under_cnt[p] = bump(under_cnt[p]);
						over_cnt[p]  = '0;
						far_cnt[p]   = '0;
						if (under_cnt[p] >= t_under) begin
							under_cnt[p] = '0;
							trip = 1'b1;
						end
					end else if (x > far_lvl) begin
						deep_cnt[p]  = '0;
						under_cnt[p] = '0;
						over_cnt[p]  = bump(over_cnt[p]);
						far_cnt[p]   = bump(far_cnt[p]);
						if (far_cnt[p] >= t_far) begin
							over_cnt[p] = '0;
							far_cnt[p]  = '0;
							trip = 1'b1;
						end
					end else if (x > over_lvl) begin
						deep_cnt[p]  = '0;
						under_cnt[p] = '0;
						over_cnt[p]  = bump(over_cnt[p]);
						far_cnt[p]   = '0;
						if (over_cnt[p] >= t_over) begin
							over_cnt[p] = '0;
							trip = 1'b1;
						end
					end else begin
						deep_cnt[p]  = '0;
						under_cnt[p] = '0;
						over_cnt[p]  = '0;
						far_cnt[p]   = '0;
					end
				end
			end else begin
				for (int p = 0; p < n; p++) begin
					if (volt[p] < win_lo || volt[p] > win_hi)
						reconnect_cnt = '0;
				end
				reconnect_cnt = bump(reconnect_cnt);
				if (reconnect_cnt > recover_tim) begin
					clear_counts();
					trip = 1'b0;
				end else begin
					trip = 1'b1;
				end
			end
			fault_due.push_back(trip);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_verdict(logic [7:0] beat);
			bit want;
			if (fault_due.size() == 0) begin
				report($sformatf("result beat %h with nothing outstanding", beat));
				return;
			end
			want = fault_due.pop_front();
			if (beat[0] !== want)
				report($sformatf("fault %b, predicted %b", beat[0], want));
			if (beat[7:1] !== 7'd0)
				report($sformatf("padding bits %b not zero", beat[7:1]));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [47:0]      s_tdata;   // volt_phase_a, volt_phase_b, volt_phase_c
	logic             s_tuser;   // fault_latched
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;   // fault, zero padding

	trip_scoreboard sb = new();
	bit             calm;

	grid_voltage_trip_monitor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_verdict(m_tdata);
	end

	function automatic volt_set_t three(bit [15:0] a, bit [15:0] b, bit [15:0] c);
		return {c, b, a};
	endfunction

	// a voltage inside the band of the given class, or anything if the band is empty
	function automatic bit [VOLT_W-1:0] pick_volt(volt_kind_t k);
		int lo, hi;
		case (k)
			V_DEEP: begin
				lo = 0;
				hi = int'(sb.under_thr[15:0]) - 1;
			end
			V_UNDER: begin
				lo = int'(sb.under_thr[15:0]);
				hi = int'(sb.under_thr[31:16]) - 1;
			end
			V_NORMAL: begin
				lo = int'(sb.under_thr[31:16]);
				hi = int'(sb.over_thr[15:0]);
			end
			V_OVER: begin
				lo = int'(sb.over_thr[15:0]) + 1;
				hi = int'(sb.over_thr[31:16]);
			end
			V_FAR: begin
				lo = int'(sb.over_thr[31:16]) + 1;
				hi = 65535;
			end
			V_WINDOW: begin
				lo = int'(sb.recover_win[15:0]);
				hi = int'(sb.recover_win[31:16]);
			end
			default: begin
				lo = 0;
				hi = 65535;
			end
		endcase
		if (lo < 0 || hi < 0 || lo > 65535 || hi > 65535 || lo > hi)
			return VOLT_W'($urandom);
		return VOLT_W'($urandom_range(hi, lo));
	endfunction

	task automatic send_sample(input volt_set_t volt, input bit in_fault);
		while (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= volt;
		s_tuser  <= in_fault;
		do @(posedge clk); while (!s_tready);
		sb.take_sample(volt, in_fault);
		@(negedge clk);
	endtask

	// hold off until every decision has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.fault_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(input logic [CFG_W-1:0] u_thr, o_thr, win, u_tim, o_tim,
	                         rec_t, ph_cnt);
		write_reg(REG_UNDER_THR, u_thr);
		write_reg(REG_OVER_THR, o_thr);
		write_reg(REG_RECOVER_W, win);
		write_reg(REG_UNDER_TIM, u_tim);
		write_reg(REG_OVER_TIM, o_tim);
		write_reg(REG_RECOVER_T, rec_t);
		write_reg(REG_PHASE_CNT, ph_cnt);
	endtask

	task automatic random_settings(input int k);
		bit [15:0] deep_l, under_l, over_l, far_l;
		int        ph;
		ph = $urandom_range(5);
		if (ph > 3)
			ph = 3;
		if (k == 2) begin
			write_all('1, '1, '1, '1, '1, '1, '1);
		end else if (k == 7) begin
			write_all('0, '0, '0, '0, '0, '0, '0);
		end else if (k % 4 == 3) begin
			write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			          ($urandom & ~32'h3) | ph);
		end else begin
			// ordered levels and short times so that trips and releases are frequent
			deep_l  = $urandom_range(3000, 500);
			under_l = deep_l + $urandom_range(3000);
			over_l  = under_l + $urandom_range(8000);
			far_l   = over_l + $urandom_range(8000);
			write_all({under_l, deep_l}, {far_l, over_l},
			          {16'(over_l + $urandom_range(500)), 16'(under_l + $urandom_range(500))},
			          {16'($urandom_range(6)), 16'($urandom_range(6))},
			          {16'($urandom_range(6)), 16'($urandom_range(6))},
			          ($urandom & 32'hFFFF_0000) | $urandom_range(12),
			          ($urandom & ~32'h3) | ph);
		end
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE, $urandom);
	endtask

	task automatic random_samples(input int items);
		int         sent;
		int         len;
		bit         in_fault;
		volt_kind_t kind [PHASES];
		volt_set_t  volt;
		sent = 0;
		while (sent < items) begin
			len      = $urandom_range(10, 1);
			in_fault = ($urandom_range(99) < 25);
			for (int p = 0; p < PHASES; p++) begin
				if (in_fault)
					kind[p] = ($urandom_range(99) < 85) ? V_WINDOW : V_ANY;
				else if ($urandom_range(99) < 15)
					kind[p] = V_ANY;
				else
					kind[p] = volt_kind_t'($urandom_range(V_FAR, V_DEEP));
			end
			for (int i = 0; i < len && sent < items; i++) begin
				for (int p = 0; p < PHASES; p++)
					volt[p] = pick_volt(($urandom_range(99) < 10) ? V_ANY : kind[p]);
				send_sample(volt, ($urandom_range(99) < 3) ? !in_fault : in_fault);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		calm      = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: all levels zero, three phases
		send_sample(three(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
		send_sample(three(16'h0000, 16'h0000, 16'h0000), 1'b0);
		send_sample(three(16'h0000, 16'h0000, 16'h0000), 1'b1);
		settle();

		// deep time 1, under time 2, far time zero, over time 2, release after 2
		write_all({16'd2000, 16'd1000}, {16'd4000, 16'd3000}, {16'd3500, 16'd2500},
		          {16'd1, 16'd2}, {16'd0, 16'd2}, 32'd2, 32'd3);
		send_sample(three(0, 2500, 2500), 1'b0);
		send_sample(three(2500, 1500, 65535), 1'b0);
		send_sample(three(2500, 1500, 65535), 1'b0);     // phase c left alone
		send_sample(three(3500, 2500, 2500), 1'b0);
		send_sample(three(3500, 2500, 2500), 1'b0);
		repeat (4) send_sample(three(3000, 3000, 3000), 1'b1);
		send_sample(three(3000, 4000, 3000), 1'b1);      // leaves the window
		settle();

		// no phase checked
		write_reg(REG_PHASE_CNT, 32'd0);
		send_sample(three(0, 0, 0), 1'b0);
		send_sample(three(65535, 0, 0), 1'b1);
		send_sample(three(65535, 0, 0), 1'b1);
		settle();

		// phase a only, upper data bits set
		write_reg(REG_PHASE_CNT, 32'hFFFF_FFFD);
		send_sample(three(2500, 0, 65535), 1'b0);
		send_sample(three(3000, 65535, 0), 1'b1);
		settle();
		write_reg(REG_SPARE, $urandom);
		write_reg(REG_RECOVER_T, 32'hABCD_0001);
		send_sample(three(3000, 0, 0), 1'b1);
		send_sample(three(3000, 0, 0), 1'b1);
		settle();

		for (int k = 0; k < 12; k++) begin
			random_settings(k);
			calm = (k == 5);
			random_samples(150);
			calm = 1'b0;
			settle();
		end

		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
sv/gvtm_pkg.sv
sv/gvtm_lane.sv
sv/gvtm_merge.sv
sv/grid_voltage_trip_monitor.sv
tb/sv/tb.sv
